[rtl/kss_pkg.sv]
package kss_pkg;

  localparam int VAL_W = 32;
  localparam int K_W   = 7;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] kth_value;
    logic                    too_few;
  } result_t;

endpackage

[rtl/kth_smallest_stream_select.sv]
// k-th smallest value of each set in a stream of signed 32-bit values.
//
// Input channel (in_valid / in_stall / in_data): one value per beat, with
// in_data.last on the final value of a set. Output channel (out_valid /
// out_stall / out_data): one beat per set, carrying the heap top (the k-th
// smallest value) and too_few when the set held fewer than k values.
// Config channel (cfg_valid / cfg_ready / cfg_data): writes k_reg; write
// it only while the block is idle. k of 0 acts as 1, above CAPACITY as CAPACITY.
//
// One beat is worked on at a time: the input stalls until the sequencer is
// back in S_IDLE. A dropped value needs no heap access; an insert walks up
// through S_UP_RD and S_UP_CMP, a top replacement walks down through S_DN_RD
// and S_DN_CMP, one level per read and compare pair, until the walk ends on a
// compare or at the root or a leaf. Each sift level is a read, then a compare
// and write-back, in the registered-read heap RAM. A last beat then passes
// through S_FIN, which loads the output register and raises out_valid. A
// result held by out_stall stalls the input only once the next set ends;
// beats before that keep flowing.
// Reset (rst, synchronous) empties the heap and sets k_reg to 1; the
// heap RAM is not cleared, since only entries below the fill count are used.
module kth_smallest_stream_select #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  kss_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output kss_pkg::result_t   out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_data
);
  import kss_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int KW = (CW > K_W) ? CW : K_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UP_RD  = 3'd1;
  localparam logic [2:0] S_UP_CMP = 3'd2;
  localparam logic [2:0] S_DN_RD  = 3'd3;
  localparam logic [2:0] S_DN_CMP = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  // Heap RAM and its registered read data
  logic signed [VAL_W-1:0] heap_mem [CAPACITY];
  logic signed [VAL_W-1:0] rd_a;
  logic signed [VAL_W-1:0] rd_b;

  logic [2:0]              state, state_next;
  logic [CW-1:0]           count, count_next;
  logic [CW-1:0]           pos, pos_next;
  logic [K_W-1:0]          k_reg;
  logic [CW-1:0]           k_r;
  logic signed [VAL_W-1:0] v_r;
  logic                    last_r;
  logic signed [VAL_W-1:0] top_val;

  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic signed [VAL_W-1:0] wr_data;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr_a, rd_addr_b;

  logic [KW-1:0]           k_wide;
  logic [CW-1:0]           k_eff;
  logic                    in_take;
  logic                    out_load;
  logic [CW:0]             lchild, rchild, cnt_w;
  logic [CW-1:0]           parent;
  logic signed [VAL_W-1:0] big_val;
  logic [1:0]              big_sel;

  // Clamp k into 1..CAPACITY
  always_comb begin
    k_wide = KW'(k_reg);
    if (k_wide == '0) begin
      k_eff = CW'(1);
    end else if (k_wide > KW'(CAPACITY)) begin
      k_eff = CW'(CAPACITY);
    end else begin
      k_eff = k_wide[CW-1:0];
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_load  = (state == S_FIN) && (!out_valid || !out_stall);

  assign lchild = {pos, 1'b1};
  assign rchild = lchild + (CW+1)'(1);
  assign cnt_w  = {1'b0, count};
  assign parent = (pos - CW'(1)) >> 1;

  // Pick the larger child, left wins ties against the right
  always_comb begin
    big_val = v_r;
    big_sel = 2'd0;
    if (lchild < cnt_w && rd_a > big_val) begin
      big_val = rd_a;
      big_sel = 2'd1;
    end
    if (rchild < cnt_w && rd_b > big_val) begin
      big_val = rd_b;
      big_sel = 2'd2;
    end
  end

  // Sequencer: the value being placed rides in v_r while a hole walks the tree.
  // A write and the following read never share an address, since the walk
  // moves strictly up or strictly down.
  always_comb begin
    state_next = state;
    count_next = count;
    pos_next   = pos;
    wr_en      = 1'b0;
    wr_addr    = pos[AW-1:0];
    wr_data    = v_r;
    rd_en      = 1'b0;
    rd_addr_a  = lchild[AW-1:0];
    rd_addr_b  = rchild[AW-1:0];
    case (state)
      S_IDLE: begin
        if (in_take) begin
          if (count < k_eff) begin
            pos_next   = count;
            count_next = count + CW'(1);
            state_next = S_UP_RD;
          end else if (count != '0 && in_data.value < top_val) begin
            pos_next   = '0;
            state_next = S_DN_RD;
          end else begin
            state_next = in_data.last ? S_FIN : S_IDLE;
          end
        end
      end
      S_UP_RD: begin
        if (pos == '0) begin
          wr_en      = 1'b1;
          state_next = last_r ? S_FIN : S_IDLE;
        end else begin
          rd_en      = 1'b1;
          rd_addr_a  = parent[AW-1:0];
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        wr_en = 1'b1;
        if (rd_a >= v_r) begin
          state_next = last_r ? S_FIN : S_IDLE;
        end else begin
          wr_data    = rd_a;
          pos_next   = parent;
          state_next = S_UP_RD;
        end
      end
      S_DN_RD: begin
        if (lchild >= cnt_w) begin
          wr_en      = 1'b1;
          state_next = last_r ? S_FIN : S_IDLE;
        end else begin
          rd_en      = 1'b1;
          state_next = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        wr_en = 1'b1;
        if (big_sel == 2'd0) begin
          state_next = last_r ? S_FIN : S_IDLE;
        end else begin
          wr_data    = big_val;
          pos_next   = (big_sel == 2'd1) ? lchild[CW-1:0] : rchild[CW-1:0];
          state_next = S_DN_RD;
        end
      end
      S_FIN: begin
        if (out_load) begin
          count_next = '0;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Heap RAM: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a <= heap_mem[rd_addr_a];
      rd_b <= heap_mem[rd_addr_b];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      k_reg     <= K_W'(1);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg_valid && cfg_ready) begin
        k_reg <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end
    end
  end

  // Payload: hold the beat in flight, mirror the heap top, load the result
  always_ff @(posedge clk) begin
    pos <= pos_next;
    if (in_take) begin
      v_r    <= in_data.value;
      last_r <= in_data.last;
      k_r    <= k_eff;
    end
    if (wr_en && wr_addr == '0) begin
      top_val <= wr_data;
    end
    if (out_load) begin
      out_data.kth_value <= top_val;
      out_data.too_few   <= (count < k_r);
    end
  end

  // Fill count never passes the heap capacity
  assert property (@(posedge clk) disable iff (rst) count <= CW'(CAPACITY))
    else $error("heap fill count above capacity");

  // Writes land only inside the filled part of the heap
  assert property (@(posedge clk) disable iff (rst) wr_en |-> (CW'(wr_addr) < count))
    else $error("heap write beyond fill count");

  // A port-a read issued with a write never targets the entry being written
  assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (rd_addr_a != wr_addr))
    else $error("heap read collides with write");

  // Finishing a set presents a result and empties the heap
  assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && count == '0 && state == S_IDLE))
    else $error("set end did not load result and clear heap");

  // No input beat is taken during the compare step of a sift
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DN_CMP || state == S_UP_CMP) |-> in_stall)
    else $error("input accepted during sift");

endmodule

[tb/kth_smallest_stream_select_test.sv]
module kth_smallest_stream_select_test;
  timeunit 1ns;
  timeprecision 1ps;

  import kss_pkg::*;

  localparam int CAP = 64;
  // Longest busy stretch of one beat, plus the output load, rounded up.
  localparam int SETTLE_CYCLES = 24;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_stall;
  in_item_t       in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  result_t        out_data;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [6:0]     cfg_data = '0;

  kth_smallest_stream_select #(
    .CAPACITY(CAP)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Values still to be offered, and the k-th smallest results owed by the block.
  in_item_t           value_queue[$];
  result_t            kth_due[$];
  int unsigned        values_fed = 0;
  int unsigned        values_taken = 0;
  int unsigned        results_checked = 0;
  int unsigned        mismatches = 0;

  // Shadow of the block: rank register and the bounded max-heap of the open set.
  logic [6:0]         k_reg = 7'd1;
  logic signed [31:0] heap_vals[CAP];
  int unsigned        heap_n = 0;

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // Absorb one accepted value into the shadow heap; on the last value of a set,
  // queue the heap top as the owed result and empty the heap.
  function automatic void absorb_value(input in_item_t it);
    int unsigned        k_eff;
    int unsigned        pos;
    int unsigned        par;
    int unsigned        lch;
    int unsigned        rch;
    int unsigned        big;
    logic signed [31:0] v;
    logic signed [31:0] tmp;
    result_t            res;
    v = it.value;
    // Clamp k into 1..CAP on every beat, as the block does.
    k_eff = (k_reg == 7'd0) ? 1 : ((k_reg > CAP) ? CAP : k_reg);
    if (heap_n < k_eff && heap_n < CAP) begin
      // Still filling: insert at the tail and sift up.
      heap_vals[heap_n] = v;
      pos = heap_n;
      heap_n++;
      while (pos > 0) begin
        par = (pos - 1) / 2;
        if (heap_vals[par] >= heap_vals[pos]) break;
        tmp = heap_vals[par];
        heap_vals[par] = heap_vals[pos];
        heap_vals[pos] = tmp;
        pos = par;
      end
    end else if (heap_n > 0 && v < heap_vals[0]) begin
      // Full: a strictly smaller value replaces the top and sifts down.
      heap_vals[0] = v;
      pos = 0;
      while (1) begin
        lch = 2 * pos + 1;
        rch = lch + 1;
        big = pos;
        if (lch < heap_n && heap_vals[lch] > heap_vals[big]) big = lch;
        if (rch < heap_n && heap_vals[rch] > heap_vals[big]) big = rch;
        if (big == pos) break;
        tmp = heap_vals[big];
        heap_vals[big] = heap_vals[pos];
        heap_vals[pos] = tmp;
        pos = big;
      end
    end
    if (it.last) begin
      res.kth_value = (heap_n > 0) ? heap_vals[0] : '0;
      res.too_few   = (heap_n < k_eff);
      kth_due = {kth_due, res};
      heap_n = 0;
    end
  endfunction

  // Driver: offer queued values in bursts of random length with random gaps.
  // A stalled beat holds its payload and valid until it is taken.
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        // Predict first, then count, so a waiting phase never sees a taken
        // beat whose result is not yet owed.
        absorb_value(in_data);
        values_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (value_queue.size() > 0) begin
          in_data  <= value_queue.pop_front();
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall on a pattern that changes mode now and then, and once every
  // 40 results hold off for a random stretch so the block fills and stalls its input.
  int          stall_mode = 0;
  int          mode_left = 0;
  int          hold_left = 0;
  int unsigned hold_mark = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (results_checked % 40 == 20 && hold_mark != results_checked) begin
      hold_mark = results_checked;
      hold_left = $urandom_range(300, 500);
      out_stall <= 1'b1;
    end else begin
      if (mode_left <= 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(64, 256);
      end
      mode_left--;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 9) < 3);
        default: out_stall <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  // Monitor: compare each taken result beat with the oldest owed result.
  result_t want;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (kth_due.size() == 0) begin
        flag_mismatch($sformatf("result beat with no set closed: kth_value=%0d too_few=%0d",
                                out_data.kth_value, out_data.too_few));
      end else begin
        want = kth_due.pop_front();
        if (out_data.kth_value !== want.kth_value)
          flag_mismatch($sformatf("kth_value got %0d want %0d",
                                  out_data.kth_value, want.kth_value));
        if (out_data.too_few !== want.too_few)
          flag_mismatch($sformatf("too_few got %0d want %0d",
                                  out_data.too_few, want.too_few));
      end
      results_checked++;
    end
  end

  task automatic queue_value(input logic signed [31:0] v, input logic lst);
    in_item_t it;
    it.value = v;
    it.last  = lst;
    value_queue = {value_queue, it};
    values_fed++;
  endtask

  // Hold the sender until every beat is taken and every result is back, then
  // give a beat that closes no set time to finish inside the block.
  task automatic settle();
    while (values_taken != values_fed || kth_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_k(input logic [6:0] kv);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= kv;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    k_reg = kv;
  endtask

  // Mix extremes, a narrow band that makes ties likely, and full-range values.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000 + $urandom_range(0, 3);
      1:       return 32'h7fff_ffff - $urandom_range(0, 3);
      2, 3:    return $urandom_range(0, 16) - 32'd8;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int         p;
    int         i;
    int         n;
    int         fed;
    int         keff;
    logic [6:0] kv;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // k at its reset value of 1: a lone most-negative value, then a minimum hunt.
    queue_value(32'sh8000_0000, 1'b1);
    queue_value(5, 1'b0);
    queue_value(7, 1'b0);
    queue_value(-3, 1'b0);
    queue_value(32'sh7fff_ffff, 1'b1);

    // k of 0 behaves as 1.
    write_k(7'd0);
    queue_value(32'sh7fff_ffff, 1'b1);

    // Set shorter than k, then ties with the top that must be dropped.
    write_k(7'd3);
    queue_value(10, 1'b0);
    queue_value(20, 1'b1);
    queue_value(4, 1'b0);
    queue_value(4, 1'b0);
    queue_value(4, 1'b0);
    queue_value(4, 1'b0);
    queue_value(1, 1'b1);

    // k beyond capacity clamps to capacity.
    write_k(7'd127);
    queue_value(-1, 1'b0);
    queue_value(0, 1'b1);

    // Lower k in the middle of a set: the extra entries stay, only the top moves.
    write_k(7'd4);
    queue_value(8, 1'b0);
    queue_value(6, 1'b0);
    queue_value(4, 1'b0);
    queue_value(2, 1'b0);
    write_k(7'd2);
    queue_value(3, 1'b0);
    queue_value(1, 1'b0);
    queue_value(9, 1'b1);

    // Random phases, one rank each; a phase may leave its last set open so
    // that the next rank applies mid-set.
    for (p = 0; p < 8; p++) begin
      case (p)
        0:       kv = 7'd64;
        1:       kv = 7'd1;
        2:       kv = 7'd7;
        3:       kv = 7'd127;
        4:       kv = 7'd3;
        5:       kv = 7'd0;
        6:       kv = 7'd16;
        default: kv = $urandom_range(0, 127);
      endcase
      write_k(kv);
      keff = (kv == 0) ? 1 : ((kv > CAP) ? CAP : kv);
      fed = 0;
      while (fed < 56) begin
        n = $urandom_range(1, 2 * keff + 3);
        if (n > 90) n = $urandom_range(60, 90);
        for (i = 0; i < n; i++)
          queue_value(pick_value(), i == n - 1);
        fed += n;
      end
      if (p != 7 && $urandom_range(0, 1) == 1) begin
        n = $urandom_range(1, keff + 2);
        for (i = 0; i < n; i++)
          queue_value(pick_value(), 1'b0);
      end
    end

    settle();
    repeat (16) @(posedge clk);
    if (mismatches == 0)
      $display("** kth_smallest_stream_select: PASSED **");
    else
      $display("** kth_smallest_stream_select: FAILED **");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("** kth_smallest_stream_select: FAILED **");
    $finish;
  end

endmodule
